// File: sv/hsrm_pkg.sv
`default_nettype none
package hsrm_pkg;

  localparam int HashBits      = 10;
  localparam int SlotsPerRow   = 3;
  localparam int RowsPerBucket = 2;

  localparam int NumBuckets = 1 << HashBits;
  localparam int TagDepth   = NumBuckets * RowsPerBucket;
  localparam int ValDepth   = TagDepth * SlotsPerRow;
  localparam int TagAw      = $clog2(TagDepth);
  localparam int ValAw      = $clog2(ValDepth);
  localparam int SlotW      = (SlotsPerRow > 1) ? $clog2(SlotsPerRow) : 1;
  localparam int RowW       = (RowsPerBucket > 1) ? $clog2(RowsPerBucket) : 1;
  localparam int ScanW      = $clog2(RowsPerBucket + 1);

  localparam logic [31:0] FnvPrime = 32'h0100_0193;
  localparam logic [31:0] FnvSeed  = 32'h811C_9DC5;
  localparam logic [63:0] TagEmpty = '1;

  typedef enum logic [1:0] {
    StMatched = 2'd0,
    StStored  = 2'd1,
    StFull    = 2'd2
  } status_e;

endpackage
`default_nettype wire

// File: sv/hsrm_if.sv
`default_nettype none
interface hsrm_req_if;
  logic        valid;
  logic        ready;
  logic [62:0] key;
  logic        side;
  logic [63:0] value_in;

  modport source (output valid, key, side, value_in, input ready);
  modport sink (input valid, key, side, value_in, output ready);
endinterface

interface hsrm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface
`default_nettype wire

// File: sv/hashed_send_receive_match_table_core.sv
`default_nettype none
// Send/receive match table: each request transaction is hashed with byte-wise
// FNV-1a to a bucket of RowsPerBucket rows of SlotsPerRow tag slots; the first
// slot holding the same key from the opposite side is released and its value
// returned, else the request takes the first free slot, else status full is
// returned. One request is in flight at a time. Its steps are: the hash, one
// multiply per key byte; the scan, one row read per cycle from the tag memory,
// whose read is registered; the update of the tag and value memories; and the
// load of the result register. The block returns to idle as the result is
// loaded and then accepts the next request. A result held by a stalled sink
// keeps the next result from loading, so the block waits in finish and
// accepts no new request until the sink takes it. After reset the tag memory
// is cleared one row per cycle, all TagDepth rows (2048 by default), before
// the first request is accepted.
module hashed_send_receive_match_table_core
  import hsrm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hsrm_req_if.sink  req_i,
  hsrm_rsp_if.source rsp_o
);

  localparam logic [2:0] SClear  = 3'd0;
  localparam logic [2:0] SIdle   = 3'd1;
  localparam logic [2:0] SHash   = 3'd2;
  localparam logic [2:0] SScan   = 3'd3;
  localparam logic [2:0] SDecide = 3'd4;
  localparam logic [2:0] SFinish = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [TagAw-1:0] clr_q, clr_d;
  logic [2:0]       hcnt_q, hcnt_d;
  logic [ScanW-1:0] sc_q, sc_d;
  logic [62:0]      key_q;
  logic             side_q;
  logic [63:0]      val_q;
  logic [31:0]      h_q, h_d;
  logic             found_q, found_d, empty_q, empty_d;
  logic [RowW-1:0]  m_row_q, m_row_d, e_row_q, e_row_d;
  logic [SlotW-1:0] m_slot_q, m_slot_d, e_slot_q, e_slot_d;
  status_e          st_q, st_d;
  logic             out_valid_q;
  status_e          out_st_q;
  logic [63:0]      out_val_q;

  logic [63:0]      tag_mem [TagDepth][SlotsPerRow];
  logic [63:0]      val_mem [ValDepth];
  logic [63:0]      rd_q [SlotsPerRow];
  logic             rd_vld_q;
  logic [RowW-1:0]  rd_row_q;
  logic [63:0]      vrd_q;

  logic             tw_en, tw_all;
  logic [TagAw-1:0] tw_addr;
  logic [SlotW-1:0] tw_slot;
  logic [63:0]      tw_data;
  logic             tr_en;
  logic [TagAw-1:0] tr_addr;
  logic             vw_en, vr_en;
  logic [ValAw-1:0] v_addr;

  logic [HashBits-1:0] bucket;
  logic [63:0]      my_tag, partner;
  logic [63:0]      key64;
  logic [7:0]       kbyte;
  logic [31:0]      hmix;
  logic             out_free;

  function automatic logic [TagAw-1:0] row_addr(logic [HashBits-1:0] b, logic [RowW-1:0] r);
    return TagAw'(b) * TagAw'(RowsPerBucket) + TagAw'(r);
  endfunction

  function automatic logic [ValAw-1:0] slot_addr(logic [TagAw-1:0] ra, logic [SlotW-1:0] s);
    return ValAw'(ra) * ValAw'(SlotsPerRow) + ValAw'(s);
  endfunction

  assign bucket   = HashBits'((h_q >> HashBits) ^ h_q);
  assign my_tag   = {key_q, side_q};
  assign partner  = {key_q, ~side_q};
  assign key64    = {1'b0, key_q};
  assign kbyte    = key64[{hcnt_q, 3'b000} +: 8];
  assign hmix     = h_q ^ {24'b0, kbyte};
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready     = (state_q == SIdle);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_st_q;
  assign rsp_o.value_out = out_val_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    hcnt_d   = hcnt_q;
    sc_d     = sc_q;
    h_d      = h_q;
    found_d  = found_q;
    empty_d  = empty_q;
    m_row_d  = m_row_q;
    m_slot_d = m_slot_q;
    e_row_d  = e_row_q;
    e_slot_d = e_slot_q;
    st_d     = st_q;
    tw_en    = 1'b0;
    tw_all   = 1'b0;
    tw_addr  = row_addr(bucket, m_row_q);
    tw_slot  = m_slot_q;
    tw_data  = TagEmpty;
    tr_en    = 1'b0;
    tr_addr  = row_addr(bucket, sc_q[RowW-1:0]);
    vw_en    = 1'b0;
    vr_en    = 1'b0;
    v_addr   = slot_addr(row_addr(bucket, m_row_q), m_slot_q);
    unique case (state_q)
      SClear: begin
        tw_en   = 1'b1;
        tw_all  = 1'b1;
        tw_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == TagAw'(TagDepth - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (req_i.valid) begin
          state_d = SHash;
          hcnt_d  = '0;
          h_d     = FnvSeed;
          found_d = 1'b0;
          empty_d = 1'b0;
          sc_d    = '0;
        end
      end
      SHash: begin
        h_d    = hmix * FnvPrime;
        hcnt_d = hcnt_q + 1'b1;
        if (hcnt_q == 3'd7) begin
          state_d = SScan;
        end
      end
      SScan: begin
        tr_en = (sc_q < ScanW'(RowsPerBucket));
        sc_d  = sc_q + 1'b1;
        if (rd_vld_q) begin
          for (int s = 0; s < SlotsPerRow; s++) begin
            if (!found_d && rd_q[s] == partner) begin
              found_d  = 1'b1;
              m_row_d  = rd_row_q;
              m_slot_d = SlotW'(s);
            end
            if (!empty_d && rd_q[s] == TagEmpty) begin
              empty_d  = 1'b1;
              e_row_d  = rd_row_q;
              e_slot_d = SlotW'(s);
            end
          end
        end
        if (sc_q == ScanW'(RowsPerBucket)) begin
          state_d = SDecide;
        end
      end
      SDecide: begin
        state_d = SFinish;
        if (found_q) begin
          tw_en = 1'b1;
          vr_en = 1'b1;
          st_d  = StMatched;
        end else if (empty_q && my_tag != TagEmpty) begin
          tw_en   = 1'b1;
          tw_addr = row_addr(bucket, e_row_q);
          tw_slot = e_slot_q;
          tw_data = my_tag;
          vw_en   = 1'b1;
          v_addr  = slot_addr(row_addr(bucket, e_row_q), e_slot_q);
          st_d    = StStored;
        end else begin
          st_d = StFull;
        end
      end
      SFinish: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      hcnt_q      <= '0;
      sc_q        <= '0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      hcnt_q   <= hcnt_d;
      sc_q     <= sc_d;
      found_q  <= found_d;
      empty_q  <= empty_d;
      rd_vld_q <= tr_en;
      if (state_q == SFinish && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    m_row_q  <= m_row_d;
    m_slot_q <= m_slot_d;
    e_row_q  <= e_row_d;
    e_slot_q <= e_slot_d;
    st_q     <= st_d;
    rd_row_q <= sc_q[RowW-1:0];
    if (state_q == SIdle && req_i.valid) begin
      key_q  <= req_i.key;
      side_q <= req_i.side;
      val_q  <= req_i.value_in;
    end
    if (state_q == SFinish && out_free) begin
      out_st_q  <= st_q;
      out_val_q <= (st_q == StMatched) ? vrd_q : 64'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      if (tw_all) begin
        for (int s = 0; s < SlotsPerRow; s++) begin
          tag_mem[tw_addr][s] <= TagEmpty;
        end
      end else begin
        tag_mem[tw_addr][tw_slot] <= tw_data;
      end
    end
    if (tr_en) begin
      rd_q <= tag_mem[tr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vw_en) begin
      val_mem[v_addr] <= val_q;
    end
    if (vr_en) begin
      vrd_q <= val_mem[v_addr];
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SClear |-> !req_i.ready)
    else $error("request accepted during tag clearing");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == SFinish)
    else $error("result raised outside finish");

  a_no_store_empty_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDecide && vw_en) |-> tw_data != TagEmpty)
    else $error("empty mark stored as tag");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFinish && !out_free) |=> state_q == SFinish)
    else $error("finish left while result register busy");
`endif

endmodule
`default_nettype wire
